>>> hw/rtl/irpwcd_pkg.sv
package irpwcd_pkg;

    // decoder phases
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SENSE   = 2'd1,
        PH_WAIT    = 2'd2,
        PH_MEASURE = 2'd3
    } phase_t;

    // event kinds
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN   = 2'd2;

    localparam int unsigned TS_W    = 16;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned SHIFT_W = 8;
    localparam int unsigned BCNT_W  = 4;
    localparam int unsigned OVF_W   = 2;

    localparam logic [OVF_W-1:0] OVF_SAT = 2'd2;

    // register reset values
    localparam logic [TS_W-1:0] START_MIN_RST = 16'd20480;
    localparam logic [TS_W-1:0] DATA_MAX_RST  = 16'd2048;
    localparam logic [TS_W-1:0] ONE_MIN_RST   = 16'd1024;

endpackage

>>> hw/rtl/ir_pulse_width_code_decoder.sv
// ir pulse-width code decoder: takes timer event items (an edge capture with its 16-bit
// timestamp, or an overflow tick) and after a long start pulse followed by BITS_PER_CODE
// data pulses delivers a 3-bit code, the shifted code's low bits after DROPPED_LOW_BITS
// are dropped. every event is handled in the cycle it is accepted by a 16-bit subtract
// and three compares, so the block sustains one item per cycle unless stalled. results
// pass through a two-entry output queue (output register plus skid register): an item is
// still accepted while one result waits, and in_stall rises only when both entries hold
// a result the consumer has not taken. thresholds are to be written over the cfg port
// while idle (not enforced); cfg_ready is always high and writes to index 3 are dropped.
module ir_pulse_width_code_decoder #(
    parameter int unsigned BITS_PER_CODE    = 8,
    parameter int unsigned DROPPED_LOW_BITS = 5
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // event input
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic                                     op,
    input  logic [irpwcd_pkg::TS_W-1:0]              timestamp,
    // code output
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [irpwcd_pkg::CODE_W-1:0]            code_value,
    // register writes
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [irpwcd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [irpwcd_pkg::TS_W-1:0]              cfg_data
);

    localparam int unsigned TS_W    = irpwcd_pkg::TS_W;
    localparam int unsigned CODE_W  = irpwcd_pkg::CODE_W;
    localparam int unsigned SHIFT_W = irpwcd_pkg::SHIFT_W;
    localparam int unsigned BCNT_W  = irpwcd_pkg::BCNT_W;
    localparam int unsigned OVF_W   = irpwcd_pkg::OVF_W;
    // bit count limit, one bit wider so that a full 16-bit code compares correctly
    localparam logic [BCNT_W:0] BITS_LIM = (BCNT_W+1)'(BITS_PER_CODE);

    // threshold registers
    logic [TS_W-1:0] start_min_reg;
    logic [TS_W-1:0] data_max_reg;
    logic [TS_W-1:0] one_min_reg;

    // decoder state
    irpwcd_pkg::phase_t phase_reg, phase_next;
    logic [TS_W-1:0]    pulse_start_reg, pulse_start_next;
    logic [OVF_W-1:0]   ovf_reg, ovf_next;
    logic [BCNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;

    // output queue
    logic               out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]  out_code_reg, out_code_next;
    logic               skid_valid_reg, skid_valid_next;
    logic [CODE_W-1:0]  skid_code_reg, skid_code_next;

    logic               in_fire;
    logic               out_take;
    logic               too_many_ovf;
    logic [TS_W-1:0]    pulse_width;
    logic               start_ok;
    logic               data_ok;
    logic               bit_val;
    logic [SHIFT_W-1:0] shift_in;
    logic [SHIFT_W-1:0] shift_drop;
    logic [BCNT_W:0]    bit_cnt_inc;
    logic               code_done;
    logic               emit;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign cfg_ready = 1'b1;

    assign out_valid  = out_valid_reg;
    assign code_value = out_code_reg;

    // pulse measurement, width wraps modulo 2^16
    assign too_many_ovf = ovf_reg > 2'd1;
    assign pulse_width  = timestamp - pulse_start_reg;
    assign start_ok     = pulse_width > start_min_reg;
    assign data_ok      = pulse_width < data_max_reg;
    assign bit_val      = pulse_width > one_min_reg;
    assign shift_in     = {shift_reg[SHIFT_W-2:0], bit_val};
    assign shift_drop   = shift_in >> DROPPED_LOW_BITS;
    assign bit_cnt_inc  = {1'b0, bit_cnt_reg} + 1'b1;
    assign code_done    = bit_cnt_inc >= BITS_LIM;

    // a code comes out on a good closing data edge that completes the bit count
    assign emit = in_fire && (op == irpwcd_pkg::OP_EDGE) &&
                  (phase_reg == irpwcd_pkg::PH_MEASURE) && !too_many_ovf &&
                  data_ok && code_done;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (in_fire && op == irpwcd_pkg::OP_EDGE)
        begin
            case (phase_reg)
                irpwcd_pkg::PH_IDLE:    phase_next = irpwcd_pkg::PH_SENSE;
                irpwcd_pkg::PH_WAIT:    phase_next = irpwcd_pkg::PH_MEASURE;
                irpwcd_pkg::PH_SENSE:
                begin
                    if (!too_many_ovf && start_ok)
                        phase_next = irpwcd_pkg::PH_WAIT;
                    else
                        phase_next = irpwcd_pkg::PH_IDLE;
                end
                irpwcd_pkg::PH_MEASURE:
                begin
                    if (!too_many_ovf && data_ok && !code_done)
                        phase_next = irpwcd_pkg::PH_WAIT;
                    else
                        phase_next = irpwcd_pkg::PH_IDLE;
                end
                default:                phase_next = irpwcd_pkg::PH_IDLE;
            endcase
        end
    end

    // datapath updates per phase
    always_comb
    begin
        pulse_start_next = pulse_start_reg;
        ovf_next         = ovf_reg;
        bit_cnt_next     = bit_cnt_reg;
        shift_next       = shift_reg;
        if (in_fire)
        begin
            if (op == irpwcd_pkg::OP_TICK)
            begin
                // overflow count saturates at two
                if (ovf_reg < irpwcd_pkg::OVF_SAT)
                    ovf_next = ovf_reg + 1'b1;
            end
            else
            begin
                case (phase_reg)
                    irpwcd_pkg::PH_IDLE,
                    irpwcd_pkg::PH_WAIT:
                    begin
                        pulse_start_next = timestamp;
                        ovf_next         = '0;
                    end
                    irpwcd_pkg::PH_SENSE:
                    begin
                        if (!too_many_ovf && start_ok)
                        begin
                            shift_next   = '0;
                            bit_cnt_next = '0;
                        end
                    end
                    irpwcd_pkg::PH_MEASURE:
                    begin
                        if (!too_many_ovf && data_ok)
                        begin
                            bit_cnt_next = bit_cnt_inc[BCNT_W-1:0];
                            shift_next   = code_done ? shift_drop : shift_in;
                        end
                    end
                    default:
                    begin
                        shift_next = shift_reg;
                    end
                endcase
            end
        end
    end

    // output queue: skid entry only fills while the output entry is held
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_code_next   = out_code_reg;
        skid_valid_next = skid_valid_reg;
        skid_code_next  = skid_code_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_code_next   = skid_code_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (emit)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_code_next  = shift_drop[CODE_W-1:0];
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_code_next  = shift_drop[CODE_W-1:0];
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_min_reg   <= irpwcd_pkg::START_MIN_RST;
            data_max_reg    <= irpwcd_pkg::DATA_MAX_RST;
            one_min_reg     <= irpwcd_pkg::ONE_MIN_RST;
            phase_reg       <= irpwcd_pkg::PH_IDLE;
            pulse_start_reg <= '0;
            ovf_reg         <= '0;
            bit_cnt_reg     <= '0;
            shift_reg       <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    irpwcd_pkg::REG_START_MIN: start_min_reg <= cfg_data;
                    irpwcd_pkg::REG_DATA_MAX:  data_max_reg  <= cfg_data;
                    irpwcd_pkg::REG_ONE_MIN:   one_min_reg   <= cfg_data;
                    default:                   one_min_reg   <= one_min_reg;
                endcase
            end
            phase_reg       <= phase_next;
            pulse_start_reg <= pulse_start_next;
            ovf_reg         <= ovf_next;
            bit_cnt_reg     <= bit_cnt_next;
            shift_reg       <= shift_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_code_reg  <= out_code_next;
        skid_code_reg <= skid_code_next;
    end

    // skid entry is only ever behind a held output entry
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output entry");

    // a new result only appears after an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid && !in_stall))
        else $error("result appeared without an accepted item");

    // overflow count never passes saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg <= irpwcd_pkg::OVF_SAT)
        else $error("overflow count beyond saturation");

    // inside a code the bit count stays below the code length
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == irpwcd_pkg::PH_WAIT || phase_reg == irpwcd_pkg::PH_MEASURE)
            |-> ({1'b0, bit_cnt_reg} < BITS_LIM))
        else $error("bit count reached code length inside a code");

endmodule

>>> test/ir_code_checker.sv
module ir_code_checker
    import irpwcd_pkg::*;
#(
    parameter int unsigned BITS_PER_CODE    = 8,
    parameter int unsigned DROPPED_LOW_BITS = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 op,
    input  logic [TS_W-1:0]      timestamp,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [CODE_W-1:0]    code_value,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TS_W-1:0]      cfg_data,
    output int                   mismatches,
    output int                   codes_pending
);

    // threshold copies
    logic [TS_W-1:0]    start_min_q;
    logic [TS_W-1:0]    data_max_q;
    logic [TS_W-1:0]    one_min_q;

    // decoder state copies
    phase_t             phase_q;
    logic [TS_W-1:0]    pulse_start_q;
    logic [OVF_W-1:0]   ovf_q;
    logic [BCNT_W-1:0]  bits_q;
    logic [SHIFT_W-1:0] shift_q;

    logic [CODE_W-1:0]  codes_due [$];

    always @(posedge clk or negedge rst_n)
    begin
        logic [TS_W-1:0]   width;
        logic [BCNT_W:0]   next_bits;
        logic [CODE_W-1:0] want;
        if (!rst_n)
        begin
            start_min_q   = START_MIN_RST;
            data_max_q    = DATA_MAX_RST;
            one_min_q     = ONE_MIN_RST;
            phase_q       = PH_IDLE;
            pulse_start_q = '0;
            ovf_q         = '0;
            bits_q        = '0;
            shift_q       = '0;
            codes_due.delete();
            mismatches    <= 0;
            codes_pending <= 0;
        end
        else
        begin
            // results are registered and leave only after their item, so compare first
            if (out_valid && !out_stall)
            begin
                if (codes_due.size() == 0)
                begin
                    $error("code_value: expected none, actual %0d", code_value);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = codes_due.pop_front();
                    if (code_value !== want)
                    begin
                        $error("code_value: expected %0d, actual %0d", want, code_value);
                        mismatches <= mismatches + 1;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_START_MIN: start_min_q = cfg_data;
                    REG_DATA_MAX:  data_max_q  = cfg_data;
                    REG_ONE_MIN:   one_min_q   = cfg_data;
                    default:       ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                if (op == OP_TICK)
                begin
                    if (ovf_q < OVF_SAT)
                        ovf_q = ovf_q + 1'b1;
                end
                else if (phase_q == PH_IDLE || phase_q == PH_WAIT)
                begin
                    // opening edge
                    pulse_start_q = timestamp;
                    ovf_q         = '0;
                    phase_q       = (phase_q == PH_IDLE) ? PH_SENSE : PH_MEASURE;
                end
                else if (ovf_q >= OVF_SAT)
                    phase_q = PH_IDLE;
                else
                begin
                    width = timestamp - pulse_start_q;
                    if (phase_q == PH_SENSE)
                    begin
                        if (width > start_min_q)
                        begin
                            shift_q = '0;
                            bits_q  = '0;
                            phase_q = PH_WAIT;
                        end
                        else
                            phase_q = PH_IDLE;
                    end
                    else if (width >= data_max_q)
                        phase_q = PH_IDLE;
                    else
                    begin
                        shift_q   = {shift_q[SHIFT_W-2:0], width > one_min_q};
                        next_bits = bits_q + 1'b1;
                        bits_q    = next_bits[BCNT_W-1:0];
                        if (next_bits < BITS_PER_CODE)
                            phase_q = PH_WAIT;
                        else
                        begin
                            shift_q = shift_q >> DROPPED_LOW_BITS;
                            codes_due.push_back(shift_q[CODE_W-1:0]);
                            phase_q = PH_IDLE;
                        end
                    end
                end
            end

            codes_pending <= codes_due.size();
        end
    end

endmodule

>>> test/tb_ir_pulse_width_code_decoder.sv
module tb_ir_pulse_width_code_decoder;

    import irpwcd_pkg::*;

    localparam int unsigned CODE_BITS        = 8;
    localparam int unsigned LOW_BITS_DROPPED = 5;

    // index 3 has no register behind it, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // longest legal quiet stretch is a sender gap plus a receiver stall
    // plus the output register and the pauses before register writes;
    // the limit leaves a wide margin
    localparam int WATCHDOG_LIMIT = 1000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 op;
    logic [TS_W-1:0]      timestamp;
    logic                 out_valid;
    logic                 out_stall;
    logic [CODE_W-1:0]    code_value;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TS_W-1:0]      cfg_data;

    int mismatches;
    int codes_pending;
    int quiet_cycles = 0;

    // stimulus side copy of the thresholds, only used to shape pulse widths
    logic [TS_W-1:0] start_min_w;
    logic [TS_W-1:0] data_max_w;
    logic [TS_W-1:0] one_min_w;

    bit idle_on;      // random gaps on both channels
    int items_sent;

    always #6 clk = ~clk;

    ir_pulse_width_code_decoder #(
        .BITS_PER_CODE    (CODE_BITS),
        .DROPPED_LOW_BITS (LOW_BITS_DROPPED)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .timestamp  (timestamp),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_value (code_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    ir_code_checker #(
        .BITS_PER_CODE    (CODE_BITS),
        .DROPPED_LOW_BITS (LOW_BITS_DROPPED)
    ) code_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .timestamp     (timestamp),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .code_value    (code_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .codes_pending (codes_pending)
    );

    // one event item; returns at the edge that accepts it with valid still high,
    // so the caller either sends the next item or drops valid in the same step
    task automatic send_event(input logic kind, input logic [TS_W-1:0] ts);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= kind;
        timestamp <= ts;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // opening edge at a random time, optional ticks, closing edge width later
    // (the end timestamp wraps modulo 2^16 on its own)
    task automatic send_pulse(input logic [TS_W-1:0] width, input int ticks);
        logic [TS_W-1:0] t0;
        t0 = TS_W'($urandom);
        send_event(OP_EDGE, t0);
        repeat (ticks)
            send_event(OP_TICK, TS_W'($urandom));
        send_event(OP_EDGE, t0 + width);
    endtask

    function automatic logic [TS_W-1:0] start_width();
        if (start_min_w == '1)
            return TS_W'($urandom);
        return TS_W'($urandom_range(int'(start_min_w) + 1, 65535));
    endfunction

    // width for one data bit, sometimes right on a compare boundary
    function automatic logic [TS_W-1:0] data_width(input bit want_one);
        logic [TS_W-1:0] zero_top;
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 2))
                0:       return one_min_w;
                1:       return one_min_w + 1'b1;
                default: return data_max_w - 1'b1;
            endcase
        end
        if (want_one && int'(one_min_w) + 1 < int'(data_max_w))
            return TS_W'($urandom_range(int'(one_min_w) + 1, int'(data_max_w) - 1));
        if (data_max_w == '0)
            return TS_W'($urandom);
        zero_top = (one_min_w < data_max_w) ? one_min_w : data_max_w - 1'b1;
        return TS_W'($urandom_range(0, zero_top));
    endfunction

    // start pulse plus one data pulse per code bit; a broken frame spoils one
    // pulse (too short a start, a noisy data pulse, too many overflows) or is
    // cut short, and stops there
    task automatic send_frame(input bit broken);
        int              bad_at;
        int              fault;
        int              ticks;
        logic [TS_W-1:0] width;
        bad_at = broken ? $urandom_range(0, CODE_BITS) : -1;
        fault  = $urandom_range(0, 2);
        for (int i = 0; i <= CODE_BITS; i++)
        begin
            width = (i == 0) ? start_width() : data_width(1'($urandom_range(0, 1)));
            ticks = ($urandom_range(0, 3) == 0) ? 1 : 0;
            if (i == bad_at)
            begin
                case (fault)
                    0:
                    begin
                        if (i == 0)
                            width = TS_W'($urandom_range(0, start_min_w));
                        else
                            width = TS_W'($urandom_range(data_max_w, 65535));
                    end
                    1:       ticks = $urandom_range(2, 3);
                    default: return;
                endcase
            end
            send_pulse(width, ticks);
            if (i == bad_at)
                return;
            // ticks between pulses are cleared by the next opening edge
            if ($urandom_range(0, 9) == 0)
                send_event(OP_TICK, TS_W'($urandom));
        end
    endtask

    // mostly well-formed frames, the rest broken frames and loose events
    task automatic random_run(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_frame(1'b0);
            else if (pick < 85)
                send_frame(1'b1);
            else
                repeat ($urandom_range(1, 6))
                    send_event(1'($urandom_range(0, 1)), TS_W'($urandom));
        end
    endtask

    // sender holds off until every code has come out, then pauses before returning,
    // since the last item may have caused no code while the block still works
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (codes_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one register write, valid is left high for a following write
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_START_MIN: start_min_w = val;
            REG_DATA_MAX:  data_max_w  = val;
            REG_ONE_MIN:   one_min_w   = val;
            default:       ;
        endcase
    endtask

    task automatic set_thresholds(
        input logic [TS_W-1:0] start_min,
        input logic [TS_W-1:0] data_max,
        input logic [TS_W-1:0] one_min,
        input bit              poke_unused
    );
        wait_idle();
        if (poke_unused)
            put_reg(REG_UNUSED, TS_W'($urandom));
        put_reg(REG_START_MIN, start_min);
        put_reg(REG_DATA_MAX, data_max);
        put_reg(REG_ONE_MIN, one_min);
        cfg_valid <= 1'b0;
    endtask

    // receiver stalls in random bursts while idling is on
    initial
    begin
        int hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (idle_on && $urandom_range(0, 9) == 0)
                hold = $urandom_range(1, 13);
            out_stall <= (hold > 0);
        end
    end

    // watchdog on cycles in which no channel moves anything
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[ir_pulse_width_code_decoder] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [TS_W-1:0] bit_widths [CODE_BITS];
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        op          <= OP_EDGE;
        timestamp   <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_START_MIN;
        cfg_data    <= '0;
        start_min_w = START_MIN_RST;
        data_max_w  = DATA_MAX_RST;
        one_min_w   = ONE_MIN_RST;
        idle_on     = 1'b1;
        items_sent  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset thresholds
        // tick while idle, with an all-ones timestamp that must be ignored
        send_event(OP_TICK, 16'hFFFF);
        // overflow count saturates, closing edge then drops the pulse
        send_event(OP_EDGE, 16'h0000);
        repeat (3) send_event(OP_TICK, 16'h0000);
        send_event(OP_EDGE, 16'd30000);
        // start pulse exactly at the minimum is too short
        send_event(OP_EDGE, 16'd1000);
        send_event(OP_EDGE, 16'd21480);
        // start pulse one over the minimum, across the timer wrap
        send_event(OP_EDGE, 16'hFFF0);
        send_event(OP_EDGE, 16'hFFF0 + 16'd20481);
        // data widths on the compare boundaries: bits 1 0 1 0 1 1 0 1, code 5;
        // one tick inside the first data pulse is still tolerated
        bit_widths = '{16'd2047, 16'd1024, 16'd1025, 16'd0,
                       16'd2047, 16'd1500, 16'd3, 16'd1025};
        for (int i = 0; i < CODE_BITS; i++)
            send_pulse(bit_widths[i], (i == 0) ? 1 : 0);

        // random part over several threshold settings
        random_run(200);
        set_thresholds(16'd0, 16'hFFFF, 16'd0, 1'b0);
        random_run(200);
        // nothing can decode here: every start is short, every data pulse noise
        set_thresholds(16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
        random_run(60);
        set_thresholds(16'd100, 16'd300, 16'd150, 1'b0);
        random_run(200);
        set_thresholds(TS_W'($urandom), TS_W'($urandom), TS_W'($urandom), 1'b1);
        random_run(150);
        // back to the reset values, last stretch with no gaps or stalls
        set_thresholds(START_MIN_RST, DATA_MAX_RST, ONE_MIN_RST, 1'b0);
        idle_on = 1'b0;
        random_run(240);

        wait_idle();
        repeat (8) @(posedge clk);

        // a code still pending here was never delivered
        if (mismatches == 0 && codes_pending == 0)
            $display("[ir_pulse_width_code_decoder] OK");
        else
            $display("[ir_pulse_width_code_decoder] ERROR");
        $finish;
    end

endmodule
